// ===== hw/rtl/drl_pkg.sv =====
// Shared types and constants for the dose rate limiter.
`timescale 1ns / 1ps

package drl_pkg;

    localparam int unsigned AMOUNT_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PUMP_W   = 32;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SINGLE_DOSE  = 3'd0,
        REG_MIN_INTERVAL_MS  = 3'd1,
        REG_WINDOW_LENGTH_MS = 3'd2,
        REG_ROLLING_CAP      = 3'd3,
        REG_PUMP_MS_PER_STEP = 3'd4
    } cfg_reg_t;

    localparam logic [AMOUNT_W-1:0] MAX_SINGLE_DOSE_RST  = 16'd80;
    localparam logic [TIME_W-1:0]   MIN_INTERVAL_MS_RST  = 32'd600000;
    localparam logic [TIME_W-1:0]   WINDOW_LENGTH_MS_RST = 32'd3600000;
    localparam logic [AMOUNT_W-1:0] ROLLING_CAP_RST      = 16'd640;
    localparam logic [AMOUNT_W-1:0] PUMP_MS_PER_STEP_RST = 16'd100;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_DOSE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BOUNDS   = 2'd1,
        STATUS_INTERVAL = 2'd2,
        STATUS_CAP      = 2'd3
    } status_t;

    typedef struct packed {
        logic [AMOUNT_W-1:0] max_single_dose;
        logic [TIME_W-1:0]   min_interval_ms;
        logic [TIME_W-1:0]   window_length_ms;
        logic [AMOUNT_W-1:0] rolling_cap;
        logic [AMOUNT_W-1:0] pump_ms_per_step;
    } cfg_t;

    typedef struct packed {
        status_t             status;
        logic [PUMP_W-1:0]   pump_ms;
        logic [AMOUNT_W-1:0] rolling_total;
    } result_t;

endpackage

// ===== hw/rtl/dose_rate_limiter.sv =====
// Dose rate limiter top level: configuration registers, input and result registers.
`timescale 1ns / 1ps

// Fixed-window rate limiter for a dosing pump. Each transaction on the input
// channel is either a one-millisecond tick or a dose request; a request yields
// one result (status, pump time, window total), a tick yields none. The block
// takes one transaction per cycle while the output side is ready: an item is held
// in the input register, is decided by combinational logic including one 16x16
// multiply, and lands in the result register, from which the result is offered.
// Write configuration only while the block is idle.
module dose_rate_limiter
    import drl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [AMOUNT_W-1:0]  amount,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [PUMP_W-1:0]    pump_ms,
    output logic [AMOUNT_W-1:0]  rolling_total
);

    cfg_t                cfg_reg;
    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [AMOUNT_W-1:0] s1_amount_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             result;
    logic                out_free;
    logic                s1_fire;
    logic                s1_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_single_dose  <= MAX_SINGLE_DOSE_RST;
            cfg_reg.min_interval_ms  <= MIN_INTERVAL_MS_RST;
            cfg_reg.window_length_ms <= WINDOW_LENGTH_MS_RST;
            cfg_reg.rolling_cap      <= ROLLING_CAP_RST;
            cfg_reg.pump_ms_per_step <= PUMP_MS_PER_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_SINGLE_DOSE:  cfg_reg.max_single_dose  <= cfg_data[AMOUNT_W-1:0];
                REG_MIN_INTERVAL_MS:  cfg_reg.min_interval_ms  <= cfg_data[TIME_W-1:0];
                REG_WINDOW_LENGTH_MS: cfg_reg.window_length_ms <= cfg_data[TIME_W-1:0];
                REG_ROLLING_CAP:      cfg_reg.rolling_cap      <= cfg_data[AMOUNT_W-1:0];
                REG_PUMP_MS_PER_STEP: cfg_reg.pump_ms_per_step <= cfg_data[AMOUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_result = s1_valid_reg && (s1_kind_reg == KIND_DOSE);
    assign s1_fire   = s1_valid_reg && ((s1_kind_reg == KIND_TICK) || out_free);
    assign in_ready  = !s1_valid_reg || s1_fire;

    drl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fire   (s1_fire),
        .kind   (s1_kind_reg),
        .amount (s1_amount_reg),
        .result (result)
    );

    // Hold the input transaction until the decision stage takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_kind_reg   <= kind;
            s1_amount_reg <= amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_result)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign pump_ms       = out_reg.pump_ms;
    assign rolling_total = out_reg.rolling_total;

endmodule

// ===== hw/rtl/drl_core.sv =====
// Time counter, window and dose history state with the per-request decision logic.
`timescale 1ns / 1ps

module drl_core
    import drl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                fire,
    input  logic                kind,
    input  logic [AMOUNT_W-1:0] amount,
    output result_t             result
);

    logic [TIME_W-1:0]   time_now_reg;
    logic [TIME_W-1:0]   time_now_next;
    logic [TIME_W-1:0]   window_start_reg;
    logic [TIME_W-1:0]   window_start_next;
    logic [TIME_W-1:0]   last_dose_time_reg;
    logic [TIME_W-1:0]   last_dose_time_next;
    logic                dosed_before_reg;
    logic                dosed_before_next;
    logic [AMOUNT_W-1:0] window_total_reg;
    logic [AMOUNT_W-1:0] window_total_next;

    logic                restart;
    logic [AMOUNT_W-1:0] total_eff;
    logic                bad_bounds;
    logic                bad_interval;
    logic [AMOUNT_W:0]   sum;
    logic                bad_cap;
    logic [PUMP_W-1:0]   product;
    status_t             status;

    assign restart      = (time_now_reg - window_start_reg) > cfg.window_length_ms;
    assign total_eff    = restart ? '0 : window_total_reg;
    assign bad_bounds   = (amount == '0) || (amount > cfg.max_single_dose);
    assign bad_interval = dosed_before_reg &&
                          ((time_now_reg - last_dose_time_reg) < cfg.min_interval_ms);
    assign sum          = {1'b0, total_eff} + {1'b0, amount};
    assign bad_cap      = sum > {1'b0, cfg.rolling_cap};
    assign product      = PUMP_W'(amount) * PUMP_W'(cfg.pump_ms_per_step);

    always_comb
    begin
        priority if (bad_bounds)
        begin
            status = STATUS_BOUNDS;
        end
        else if (bad_interval)
        begin
            status = STATUS_INTERVAL;
        end
        else if (bad_cap)
        begin
            status = STATUS_CAP;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        result.status        = status;
        result.pump_ms       = (status == STATUS_OK) ? product : '0;
        result.rolling_total = (status == STATUS_OK) ? sum[AMOUNT_W-1:0] : total_eff;
    end

    always_comb
    begin
        time_now_next       = time_now_reg;
        window_start_next   = window_start_reg;
        last_dose_time_next = last_dose_time_reg;
        dosed_before_next   = dosed_before_reg;
        window_total_next   = window_total_reg;
        if (fire)
        begin
            if (kind == KIND_TICK)
            begin
                time_now_next = time_now_reg + TIME_W'(1);
            end
            else
            begin
                if (restart)
                begin
                    window_start_next = time_now_reg;
                end
                window_total_next = result.rolling_total;
                if (status == STATUS_OK)
                begin
                    last_dose_time_next = time_now_reg;
                    dosed_before_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg       <= '0;
            window_start_reg   <= '0;
            last_dose_time_reg <= '0;
            dosed_before_reg   <= 1'b0;
            window_total_reg   <= '0;
        end
        else
        begin
            time_now_reg       <= time_now_next;
            window_start_reg   <= window_start_next;
            last_dose_time_reg <= last_dose_time_next;
            dosed_before_reg   <= dosed_before_next;
            window_total_reg   <= window_total_next;
        end
    end

endmodule
